[hw/rtl/mtd_pkg.sv]
package mtd_pkg;

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_ID     = 6'b000010,
    PH_PID    = 6'b000100,
    PH_SIZE   = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_CHECK  = 6'b100000
  } mtd_phase_t;

  localparam logic [7:0] PID_SINGLE      = 8'd193;
  localparam logic [7:0] PID_DUAL        = 8'd210;
  localparam logic [7:0] MOTOR_LEFT      = 8'd1;
  localparam logic [7:0] MOTOR_RIGHT     = 8'd2;
  localparam logic [7:0] SIZE_MIN_SINGLE = 8'd17;
  localparam logic [7:0] SIZE_MIN_DUAL   = 8'd18;

  localparam logic KIND_TELEMETRY = 1'b0;
  localparam logic KIND_ERROR     = 1'b1;

  // data bytes D0..D17 are the only ones any result reads
  localparam int DATA_CAPTURE = 18;
  localparam int CAP_W        = $clog2(DATA_CAPTURE);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic               kind;
    logic               motor_select;
    logic signed [15:0] speed_rpm;
    logic signed [15:0] motor_current;
    logic [7:0]         status_byte;
    logic signed [31:0] position_count;
    logic [7:0]         temperature;
    logic               temperature_valid;
    logic               last;
  } mtd_result_t;

  typedef struct packed {
    logic [1:0]  count;
    mtd_result_t first;
    mtd_result_t second;
  } mtd_push_t;

endpackage

[hw/rtl/mtd_parser.sv]
module mtd_parser import mtd_pkg::*; #(
  parameter int FRAME_BYTES = 32,
  parameter int DATA_LIMIT  = 24
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  input  logic [7:0] host_id,
  input  logic [7:0] driver_id,
  output mtd_push_t  push
);

  localparam int IDX_W = $clog2(FRAME_BYTES + 1);

  mtd_phase_t       phase, phase_next;
  logic [1:0]       header_seen, header_seen_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [7:0]       data_seen, data_seen_next;
  logic [7:0]       data_expected, data_expected_next;

  logic [7:0] cap_id;
  logic [7:0] cap_pid;
  logic [7:0] dat [DATA_CAPTURE];

  logic [7:0] sum_in;
  logic [7:0] seen_inc;
  logic       take;
  logic       restart;
  mtd_result_t res_single, res_left, res_right, res_error;

  assign sum_in   = running_sum + rx_byte;
  assign seen_inc = data_seen + 8'd1;

  always_comb begin
    res_single = '0;
    res_single.kind              = KIND_TELEMETRY;
    res_single.motor_select      = (cap_id == MOTOR_RIGHT);
    res_single.speed_rpm         = {dat[1], dat[0]};
    res_single.motor_current     = {dat[3], dat[2]};
    res_single.status_byte       = dat[9];
    res_single.position_count    = {dat[13], dat[12], dat[11], dat[10]};
    res_single.temperature       = dat[15];
    res_single.temperature_valid = 1'b1;
    res_single.last              = 1'b1;

    res_left = '0;
    res_left.kind           = KIND_TELEMETRY;
    res_left.motor_select   = 1'b0;
    res_left.speed_rpm      = {dat[1], dat[0]};
    res_left.motor_current  = {dat[3], dat[2]};
    res_left.status_byte    = dat[4];
    res_left.position_count = {dat[8], dat[7], dat[6], dat[5]};

    res_right = '0;
    res_right.kind           = KIND_TELEMETRY;
    res_right.motor_select   = 1'b1;
    res_right.speed_rpm      = {dat[10], dat[9]};
    res_right.motor_current  = {dat[12], dat[11]};
    res_right.status_byte    = dat[13];
    res_right.position_count = {dat[17], dat[16], dat[15], dat[14]};
    res_right.last           = 1'b1;

    res_error = '0;
    res_error.kind = KIND_ERROR;
    res_error.last = 1'b1;
  end

  always_comb begin
    phase_next         = phase;
    header_seen_next   = header_seen;
    running_sum_next   = running_sum;
    byte_index_next    = byte_index;
    data_seen_next     = data_seen;
    data_expected_next = data_expected;
    take               = 1'b0;
    restart            = 1'b0;
    push               = '0;

    if (byte_index >= IDX_W'(FRAME_BYTES)) begin
      restart = 1'b1;
    end else begin
      case (phase)
        PH_HEADER: begin
          if (rx_byte == host_id || rx_byte == driver_id) begin
            take             = 1'b1;
            header_seen_next = header_seen + 2'd1;
            if (header_seen != 2'd0) phase_next = PH_ID;
          end else begin
            restart = 1'b1;
          end
        end
        PH_ID: begin
          if (rx_byte == MOTOR_LEFT || rx_byte == MOTOR_RIGHT) begin
            take       = 1'b1;
            phase_next = PH_PID;
          end else begin
            restart = 1'b1;
          end
        end
        PH_PID: begin
          take       = 1'b1;
          phase_next = PH_SIZE;
        end
        PH_SIZE: begin
          take               = 1'b1;
          data_expected_next = rx_byte;
          data_seen_next     = '0;
          phase_next         = PH_DATA;
        end
        PH_DATA: begin
          take           = 1'b1;
          data_seen_next = seen_inc;
          // a size of zero still falls through after one data byte
          if (seen_inc >= 8'(DATA_LIMIT)) restart = 1'b1;
          else if (seen_inc >= data_expected) phase_next = PH_CHECK;
        end
        PH_CHECK: begin
          take    = 1'b1;
          restart = 1'b1;
          if (sum_in != 8'd0) begin
            push.count = 2'd1;
            push.first = res_error;
          end else if (cap_pid == PID_SINGLE && data_expected >= SIZE_MIN_SINGLE) begin
            push.count = 2'd1;
            push.first = res_single;
          end else if (cap_pid == PID_DUAL && data_expected >= SIZE_MIN_DUAL) begin
            push.count  = 2'd2;
            push.first  = res_left;
            push.second = res_right;
          end
        end
        default: restart = 1'b1;
      endcase
    end

    if (take) begin
      running_sum_next = sum_in;
      byte_index_next  = byte_index + IDX_W'(1);
    end

    if (restart) begin
      phase_next         = PH_HEADER;
      header_seen_next   = '0;
      running_sum_next   = '0;
      byte_index_next    = '0;
      data_seen_next     = '0;
      data_expected_next = '0;
    end

    if (!accept) push = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      header_seen   <= '0;
      running_sum   <= '0;
      byte_index    <= '0;
      data_seen     <= '0;
      data_expected <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      header_seen   <= header_seen_next;
      running_sum   <= running_sum_next;
      byte_index    <= byte_index_next;
      data_seen     <= data_seen_next;
      data_expected <= data_expected_next;
    end
  end

  // capture only the frame bytes that results read
  always_ff @(posedge clk) begin
    if (accept && byte_index < IDX_W'(FRAME_BYTES)) begin
      if (phase == PH_ID) cap_id <= rx_byte;
      if (phase == PH_PID) cap_pid <= rx_byte;
      if (phase == PH_DATA && data_seen < 8'(DATA_CAPTURE)) begin
        dat[data_seen[CAP_W-1:0]] <= rx_byte;
      end
    end
  end

  a_check_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_CHECK) |=> (phase == PH_HEADER && byte_index == '0))
    else $error("parser did not restart after checksum byte");

  a_dual_order: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |->
      (!push.first.last && push.second.last && push.second.motor_select
       && !push.first.motor_select))
    else $error("dual-motor results out of order");

endmodule

[hw/rtl/mtd_result_queue.sv]
module mtd_result_queue import mtd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  mtd_push_t   push,
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output mtd_result_t head
);

  mtd_result_t       entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count, count_next;
  logic              pop;

  assign out_valid  = (count != '0);
  assign pop        = out_valid && !out_stall;
  // hold off input unless two more results fit
  assign full       = (count > QCNT_W'(QUEUE_DEPTH - 2));
  assign head       = entries[rd_ptr];
  assign count_next = count + QCNT_W'(push.count) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wr_ptr] <= push.first;
    if (push.count == 2'd2) entries[wr_ptr + QPTR_W'(1)] <= push.second;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> ((count + QCNT_W'(push.count)) <= QCNT_W'(QUEUE_DEPTH)))
    else $error("result queue overflow");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd0 && pop) |=> (count == $past(count) - QCNT_W'(1)))
    else $error("result queue count lost a word");

endmodule

[hw/rtl/motor_telemetry_deframer_core.sv]
// Motor driver telemetry deframer.
// Input channel: one received serial byte per word on rx_byte (in_valid / in_stall).
// Frames are two header bytes matching host_id or driver_id in either order, a
// motor id, a PID, a size, data bytes and a checksum that brings the byte sum to
// zero. Output channel (out_valid / out_stall) carries one result word per
// field set; a good dual-motor frame gives two words, left then right, and last
// marks the final word caused by one checksum byte.
// Throughput: one byte per cycle while in_stall is low. The results of a
// checksum byte are registered into the queue when that byte is taken.
// Results sit in a four-word queue; in_stall rises while more than two words
// wait, so a stalled receiver holds off input only once they pile up. Header
// id registers are written through cfg_we / cfg_index / cfg_data; the user
// must write them only while the block is idle, which the block does not enforce.
// Reset clears the parser to await a header, empties the queue and sets the
// ids to 184 and 183. Bytes that break framing are dropped silently.
module motor_telemetry_deframer_core import mtd_pkg::*; #(
  parameter int FRAME_BYTES = 32,
  parameter int DATA_LIMIT  = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic               motor_select,
  output logic signed [15:0] speed_rpm,
  output logic signed [15:0] motor_current,
  output logic [7:0]         status_byte,
  output logic signed [31:0] position_count,
  output logic [7:0]         temperature,
  output logic               temperature_valid,
  output logic               last
);

  localparam logic REG_HOST_ID   = 1'b0;
  localparam logic REG_DRIVER_ID = 1'b1;

  logic [7:0]  host_id;
  logic [7:0]  driver_id;
  logic        accept;
  mtd_push_t   push;
  mtd_result_t head;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      host_id   <= 8'd184;
      driver_id <= 8'd183;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOST_ID:   host_id   <= cfg_data;
        REG_DRIVER_ID: driver_id <= cfg_data;
        default: ;
      endcase
    end
  end

  mtd_parser #(
    .FRAME_BYTES(FRAME_BYTES),
    .DATA_LIMIT (DATA_LIMIT)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (rx_byte),
    .host_id  (host_id),
    .driver_id(driver_id),
    .push     (push)
  );

  mtd_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .head     (head)
  );

  assign kind              = head.kind;
  assign motor_select      = head.motor_select;
  assign speed_rpm         = head.speed_rpm;
  assign motor_current     = head.motor_current;
  assign status_byte       = head.status_byte;
  assign position_count    = head.position_count;
  assign temperature       = head.temperature;
  assign temperature_valid = head.temperature_valid;
  assign last              = head.last;

endmodule

[tb/sv/motor_telemetry_deframer_checker.sv]
package mtd_tb_pkg;

  typedef enum logic {
    REG_HOST_ID   = 1'b0,
    REG_DRIVER_ID = 1'b1
  } mtd_reg_t;

endpackage

module motor_telemetry_deframer_checker import mtd_pkg::*, mtd_tb_pkg::*; #(
  parameter int FRAME_BYTES = 32,
  parameter int DATA_LIMIT  = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  mtd_result_t word_out,
  output int          pending,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] HOST_ID_RESET   = 8'd184;
  localparam logic [7:0] DRIVER_ID_RESET = 8'd183;
  localparam int DATA_AT    = 5;  // frame byte that holds D0
  localparam int SHOW_LIMIT = 60;

  logic [7:0]  host_id;
  logic [7:0]  driver_id;
  mtd_phase_t  phase;
  logic [1:0]  hdr_count;
  logic [7:0]  frame_sum;
  int          fill_idx;
  logic [7:0]  data_cnt;
  logic [7:0]  data_len;
  logic [7:0]  frame_buf [FRAME_BYTES];
  mtd_result_t telemetry_due [$];
  mtd_result_t want;

  task automatic report(input string msg);
    if (fail_count < SHOW_LIMIT) $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want_v);
    if (got !== want_v) report($sformatf("%s got %0h expected %0h", name, got, want_v));
  endtask

  task automatic restart_frame();
    phase     = PH_HEADER;
    hdr_count = '0;
    frame_sum = '0;
    fill_idx  = 0;
    data_cnt  = '0;
    data_len  = '0;
  endtask

  task automatic store_byte(input logic [7:0] b);
    frame_sum = frame_sum + b;
    if (fill_idx < FRAME_BYTES) frame_buf[fill_idx] = b;
    fill_idx++;
  endtask

  function automatic logic [15:0] pick16(input int at);
    return {frame_buf[at + 1], frame_buf[at]};
  endfunction

  function automatic mtd_result_t telemetry_word(input logic right, input int base,
                                                 input int status_at, input int pos_at,
                                                 input logic with_temp, input logic is_last);
    mtd_result_t w;
    w = '0;
    w.kind           = KIND_TELEMETRY;
    w.motor_select   = right;
    w.speed_rpm      = pick16(base);
    w.motor_current  = pick16(base + 2);
    w.status_byte    = frame_buf[status_at];
    w.position_count = {pick16(pos_at + 2), pick16(pos_at)};
    if (with_temp) begin
      w.temperature       = frame_buf[DATA_AT + 15];
      w.temperature_valid = 1'b1;
    end
    w.last = is_last;
    return w;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    mtd_result_t err;
    if (fill_idx >= FRAME_BYTES) begin
      restart_frame();
    end else begin
      case (phase)
        PH_HEADER: begin
          if (b == host_id || b == driver_id) begin
            store_byte(b);
            hdr_count++;
            if (hdr_count >= 2) phase = PH_ID;
          end else begin
            restart_frame();
          end
        end
        PH_ID: begin
          if (b == MOTOR_LEFT || b == MOTOR_RIGHT) begin
            store_byte(b);
            phase = PH_PID;
          end else begin
            restart_frame();
          end
        end
        PH_PID: begin
          store_byte(b);
          phase = PH_SIZE;
        end
        PH_SIZE: begin
          data_len = b;
          data_cnt = '0;
          store_byte(b);
          phase = PH_DATA;
        end
        PH_DATA: begin
          store_byte(b);
          data_cnt++;
          // a size of zero still takes one data byte
          if (data_cnt >= DATA_LIMIT) restart_frame();
          else if (data_cnt >= data_len) phase = PH_CHECK;
        end
        PH_CHECK: begin
          store_byte(b);
          if (frame_sum != 0) begin
            err = '0;
            err.kind = KIND_ERROR;
            err.last = 1'b1;
            telemetry_due.push_back(err);
          end else if (frame_buf[3] == PID_SINGLE && data_len >= SIZE_MIN_SINGLE) begin
            telemetry_due.push_back(telemetry_word(frame_buf[2] == MOTOR_RIGHT, DATA_AT,
                                                   DATA_AT + 9, DATA_AT + 10, 1'b1, 1'b1));
          end else if (frame_buf[3] == PID_DUAL && data_len >= SIZE_MIN_DUAL) begin
            telemetry_due.push_back(telemetry_word(1'b0, DATA_AT, DATA_AT + 4,
                                                   DATA_AT + 5, 1'b0, 1'b0));
            telemetry_due.push_back(telemetry_word(1'b1, DATA_AT + 9, DATA_AT + 13,
                                                   DATA_AT + 14, 1'b0, 1'b1));
          end
          restart_frame();
        end
        default: restart_frame();
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      host_id   = HOST_ID_RESET;
      driver_id = DRIVER_ID_RESET;
      restart_frame();
      telemetry_due.delete();
      pending <= 0;
    end else begin
      // results are registered into the queue after their byte is taken, so compare before predicting
      if (out_valid && !out_stall) begin
        if (telemetry_due.size() == 0) begin
          report($sformatf("result word with none expected: %h", word_out));
        end else begin
          want = telemetry_due.pop_front();
          check_field("kind", word_out.kind, want.kind);
          check_field("motor_select", word_out.motor_select, want.motor_select);
          check_field("speed_rpm", word_out.speed_rpm, want.speed_rpm);
          check_field("motor_current", word_out.motor_current, want.motor_current);
          check_field("status_byte", word_out.status_byte, want.status_byte);
          check_field("position_count", word_out.position_count, want.position_count);
          check_field("temperature", word_out.temperature, want.temperature);
          check_field("temperature_valid", word_out.temperature_valid,
                      want.temperature_valid);
          check_field("last", word_out.last, want.last);
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_HOST_ID) host_id = cfg_data;
        else driver_id = cfg_data;
      end
      if (in_valid && !in_stall) deframe_byte(rx_byte);
      pending <= telemetry_due.size();
    end
  end

endmodule

[tb/sv/motor_telemetry_deframer_core_tb.sv]
module motor_telemetry_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mtd_pkg::*;
  import mtd_tb_pkg::*;

  localparam int FRAME_BYTES  = 32;
  localparam int DATA_LIMIT   = 24;
  localparam int RANDOM_BYTES = 1100;
  localparam int SEGMENTS     = 6;
  localparam int QUIET_LIMIT  = 3000;
  localparam logic [7:0] HOST_ID_RESET   = 8'd184;
  localparam logic [7:0] DRIVER_ID_RESET = 8'd183;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_HOST_ID;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [7:0] rx_byte = '0;
  logic out_stall = 1'b0;

  logic in_stall;
  logic out_valid;
  logic kind;
  logic motor_select;
  logic signed [15:0] speed_rpm;
  logic signed [15:0] motor_current;
  logic [7:0] status_byte;
  logic signed [31:0] position_count;
  logic [7:0] temperature;
  logic temperature_valid;
  logic last;

  int pending;
  int fail_count;
  int send_idle_pct = 15;
  int recv_idle_pct = 74;
  int unsigned sent_bytes = 0;
  int quiet_cycles = 0;
  logic [7:0] cur_host = HOST_ID_RESET;
  logic [7:0] cur_driver = DRIVER_ID_RESET;

  motor_telemetry_deframer_core #(
    .FRAME_BYTES(FRAME_BYTES),
    .DATA_LIMIT (DATA_LIMIT)
  ) DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .kind             (kind),
    .motor_select     (motor_select),
    .speed_rpm        (speed_rpm),
    .motor_current    (motor_current),
    .status_byte      (status_byte),
    .position_count   (position_count),
    .temperature      (temperature),
    .temperature_valid(temperature_valid),
    .last             (last)
  );

  motor_telemetry_deframer_checker #(
    .FRAME_BYTES(FRAME_BYTES),
    .DATA_LIMIT (DATA_LIMIT)
  ) u_telemetry_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .word_out  ({kind, motor_select, speed_rpm, motor_current, status_byte,
                 position_count, temperature, temperature_valid, last}),
    .pending   (pending),
    .fail_count(fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid stays high across back-to-back words; drop it only for a gap
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_frame(input logic [7:0] h0, input logic [7:0] h1,
                            input logic [7:0] mid, input logic [7:0] pid,
                            input logic [7:0] size, input fill_t fill, input bit corrupt);
    logic [7:0] frame_sum;
    logic [7:0] d;
    logic [7:0] chk;
    int nd;
    nd = (size == 0) ? 1 : size;
    if (nd > DATA_LIMIT) nd = DATA_LIMIT;
    frame_sum = h0 + h1 + mid + pid + size;
    send_byte(h0);
    send_byte(h1);
    send_byte(mid);
    send_byte(pid);
    send_byte(size);
    for (int k = 0; k < nd; k++) begin
      case (fill)
        FILL_ZERO: d = 8'h00;
        FILL_ONES: d = 8'hFF;
        default:   d = 8'($urandom_range(0, 255));
      endcase
      frame_sum = frame_sum + d;
      send_byte(d);
    end
    chk = 8'd0 - frame_sum;
    if (corrupt) chk = chk + 8'($urandom_range(1, 255));
    send_byte(chk);
  endtask

  task automatic random_frame();
    logic [7:0] h0;
    logic [7:0] h1;
    logic [7:0] mid;
    logic [7:0] pid;
    logic [7:0] size;
    int pick;
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    end
    h0  = $urandom_range(0, 1) ? cur_host : cur_driver;
    h1  = $urandom_range(0, 1) ? cur_host : cur_driver;
    mid = $urandom_range(0, 1) ? MOTOR_RIGHT : MOTOR_LEFT;
    if ($urandom_range(0, 19) == 0) mid = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      pid  = PID_SINGLE;
      size = 8'($urandom_range(SIZE_MIN_SINGLE, DATA_LIMIT - 1));
    end else if (pick < 85) begin
      pid  = PID_DUAL;
      size = 8'($urandom_range(SIZE_MIN_DUAL, DATA_LIMIT - 1));
    end else if (pick < 93) begin
      pid  = 8'($urandom_range(0, 255));
      size = 8'($urandom_range(0, DATA_LIMIT - 1));
    end else begin
      pid  = $urandom_range(0, 1) ? PID_SINGLE : PID_DUAL;
      size = $urandom_range(0, 1) ? 8'($urandom_range(0, 30)) : 8'($urandom_range(0, 255));
    end
    send_frame(h0, h1, mid, pid, size, FILL_RANDOM, $urandom_range(0, 9) == 0);
  endtask

  // hold input until the result queue is empty, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_ids(input logic [7:0] h, input logic [7:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HOST_ID;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_DRIVER_ID;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_host   = h;
    cur_driver = d;
  endtask

  initial begin
    int unsigned seg_start;
    bit paused;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames with the reset ids
    send_frame(HOST_ID_RESET, DRIVER_ID_RESET, MOTOR_LEFT, PID_SINGLE, 8'd17, FILL_RANDOM,
               1'b0);
    send_frame(DRIVER_ID_RESET, HOST_ID_RESET, MOTOR_RIGHT, PID_SINGLE, 8'd23, FILL_ONES,
               1'b0);
    send_frame(HOST_ID_RESET, HOST_ID_RESET, MOTOR_LEFT, PID_DUAL, 8'd18, FILL_ZERO, 1'b0);
    send_frame(DRIVER_ID_RESET, DRIVER_ID_RESET, MOTOR_RIGHT, PID_DUAL, 8'd23, FILL_ONES,
               1'b0);
    send_frame(HOST_ID_RESET, DRIVER_ID_RESET, MOTOR_LEFT, PID_SINGLE, 8'd17, FILL_RANDOM,
               1'b1);
    send_frame(DRIVER_ID_RESET, HOST_ID_RESET, MOTOR_RIGHT, PID_DUAL, 8'd20, FILL_RANDOM,
               1'b1);
    // unknown PIDs and short frames: no result
    send_frame(HOST_ID_RESET, DRIVER_ID_RESET, MOTOR_LEFT, 8'h00, 8'd20, FILL_RANDOM, 1'b0);
    send_frame(HOST_ID_RESET, DRIVER_ID_RESET, MOTOR_RIGHT, 8'hFF, 8'd5, FILL_RANDOM, 1'b0);
    send_frame(HOST_ID_RESET, DRIVER_ID_RESET, MOTOR_LEFT, PID_SINGLE, 8'd16, FILL_RANDOM,
               1'b0);
    send_frame(HOST_ID_RESET, DRIVER_ID_RESET, MOTOR_LEFT, PID_DUAL, 8'd17, FILL_RANDOM, 1'b0);
    // zero size takes one data byte
    send_frame(HOST_ID_RESET, DRIVER_ID_RESET, MOTOR_LEFT, PID_SINGLE, 8'd0, FILL_RANDOM,
               1'b0);
    send_frame(HOST_ID_RESET, DRIVER_ID_RESET, MOTOR_RIGHT, PID_SINGLE, 8'd0, FILL_RANDOM,
               1'b1);
    // data limit aborts the frame
    send_frame(HOST_ID_RESET, DRIVER_ID_RESET, MOTOR_LEFT, PID_DUAL, 8'(DATA_LIMIT), FILL_ONES,
               1'b0);
    send_frame(HOST_ID_RESET, DRIVER_ID_RESET, MOTOR_LEFT, PID_SINGLE, 8'hFF, FILL_RANDOM,
               1'b0);
    // header mismatch, then a good frame
    send_byte(8'h00);
    send_byte(HOST_ID_RESET);
    send_byte(8'h55);
    send_frame(HOST_ID_RESET, DRIVER_ID_RESET, MOTOR_RIGHT, PID_DUAL, 8'd19, FILL_RANDOM, 1'b0);
    // bad motor ids
    send_frame(HOST_ID_RESET, DRIVER_ID_RESET, 8'h00, PID_SINGLE, 8'd17, FILL_RANDOM, 1'b0);
    send_frame(HOST_ID_RESET, DRIVER_ID_RESET, 8'h03, PID_SINGLE, 8'd17, FILL_RANDOM, 1'b0);
    send_frame(HOST_ID_RESET, DRIVER_ID_RESET, 8'hFF, PID_DUAL, 8'd18, FILL_RANDOM, 1'b0);
    // a third header byte lands in the id slot and breaks the frame
    send_byte(DRIVER_ID_RESET);
    send_frame(HOST_ID_RESET, DRIVER_ID_RESET, MOTOR_LEFT, PID_SINGLE, 8'd18, FILL_RANDOM,
               1'b0);
    send_frame(HOST_ID_RESET, DRIVER_ID_RESET, MOTOR_RIGHT, PID_SINGLE, 8'd20, FILL_RANDOM,
               1'b0);
    drain_results();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      send_idle_pct = (seg < 2) ? 15 : (seg < 4) ? 74 : 0;
      recv_idle_pct = (seg < 2) ? 74 : (seg < 4) ? 15 : 0;
      case (seg)
        0:       set_ids(8'h00, 8'hFF);
        1:       set_ids(8'hFF, 8'h00);
        3:       set_ids(8'h07, 8'h07);
        5:       set_ids(HOST_ID_RESET, DRIVER_ID_RESET);
        default: set_ids(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      seg_start = sent_bytes;
      while (sent_bytes - seg_start < RANDOM_BYTES / SEGMENTS) begin
        random_frame();
        if (!paused && sent_bytes - seg_start >= RANDOM_BYTES / SEGMENTS / 2) begin
          drain_results();
          paused = 1'b1;
        end
      end
      drain_results();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
